FILE: rtl/modulated_ir_ambient_rejection_defines.svh
// Assertion macros shared by the ambient rejection RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MODULATED_IR_AMBIENT_REJECTION_DEFINES_SVH
`define MODULATED_IR_AMBIENT_REJECTION_DEFINES_SVH

// cond must hold on every clock edge outside reset
`define IRAR_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define IRAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/irar_pkg.sv
// Types and fixed constants of the modulated IR ambient rejection block.
// No dependencies; used by irar_cell, irar_level and the top level.
`default_nettype none

package irar_pkg;

   localparam int CHANNELS      = 2;
   localparam int REAR          = 0;
   localparam int FRONT         = 1;
   localparam int FIELD_BITS    = 12;
   localparam int LEVEL_BITS    = 12;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 32;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - 1 - 2 * LEVEL_BITS;

   typedef struct packed {
      logic lit;
      logic dark;
   } shift_ctl_type;

   typedef struct packed {
      logic d_load;
      logic p_load;
   } stage_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/modulated_ir_ambient_rejection.sv
// Modulated IR ambient rejection: one sample pair per transfer in, one status
// transfer out. A row of window cells per channel, running sums, 4-stage result pipe.
// Depends on irar_pkg, irar_cell, irar_level and the assertion macro header.
//
// One tick transfer is taken every clock cycle while req_tready is high; its result
// passes through four register stages (step/window update, difference, reciprocal
// product, quotient fix-up into the output register). The stages collapse bubbles, so
// input is still taken while a result waits on rsp_tready, until all four hold items.
// Window sums are kept running: each write adds the new sample and drops the one
// shifted out of the last cell, so no sum tree is needed. Reset clears windows, sums,
// step counter, emitter and levels.
`default_nettype none

`include "modulated_ir_ambient_rejection_defines.svh"

module modulated_ir_ambient_rejection #(
   parameter int WINDOW_LEN  = 4,
   parameter int CYCLE_TICKS = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [0:0]                            csr_data,   // emitter_enable
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [irar_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // rear_sample, front_sample
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [irar_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // emitter_on, rear_level,
                                                            // front_level, zero pad
   output logic [0:0]                           rsp_tuser   // levels_updated
);

   localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
   localparam int STEP_W  = $clog2(CYCLE_TICKS + 1);
   localparam int CH      = irar_pkg::CHANNELS;
   localparam int FB      = irar_pkg::FIELD_BITS;
   localparam int LB      = irar_pkg::LEVEL_BITS;
   localparam longint SUM_MAX = longint'(WINDOW_LEN) * ((64'd1 << SAMPLE_BITS) - 1);

   // configuration
   logic enable_ff;
   logic enable_in;

   assign csr_ready = 1'b1;
   assign enable_in = (csr_valid && csr_ready) ? csr_data[0] : enable_ff;

   // step sequencing
   logic              req_acc;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [STEP_W-1:0] step_next;
   logic              is_fire;
   logic              is_lit;
   logic              is_dark;
   logic              emit_ff;
   logic              emit_in;

   assign req_acc   = req_tvalid && req_tready;
   assign step_next = step_ff + STEP_W'(1);
   assign is_fire   = (step_next == STEP_W'(1));
   assign is_lit    = (step_next == STEP_W'(2));
   assign is_dark   = (step_next == STEP_W'(CYCLE_TICKS));
   assign step_in   = !req_acc ? step_ff : (is_dark ? '0 : step_next);

   always_comb begin
      emit_in = emit_ff;
      priority if (req_acc && is_fire && enable_ff) begin
         emit_in = 1'b1;
      end else if (req_acc && is_lit) begin
         emit_in = 1'b0;
      end else begin
         emit_in = emit_ff;
      end
   end

   // window cells and running sums
   irar_pkg::shift_ctl_type shift;
   logic [SAMPLE_BITS-1:0]  smp      [CH];
   logic [SAMPLE_BITS-1:0]  lit_q    [CH][WINDOW_LEN];
   logic [SAMPLE_BITS-1:0]  dark_q   [CH][WINDOW_LEN];
   logic [SUM_W-1:0]        lit_sum_ff  [CH];
   logic [SUM_W-1:0]        lit_sum_in  [CH];
   logic [SUM_W-1:0]        dark_sum_ff [CH];
   logic [SUM_W-1:0]        dark_sum_in [CH];

   assign shift.lit  = req_acc && is_lit;
   assign shift.dark = req_acc && is_dark;

   assign smp[irar_pkg::REAR]  = SAMPLE_BITS'(req_tdata[FB-1:0]);
   assign smp[irar_pkg::FRONT] = SAMPLE_BITS'(req_tdata[2*FB-1:FB]);

   for (genvar c = 0; c < CH; c++) begin : g_ch
      for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
         if (k == 0) begin : g_head
            irar_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift    (shift),
               .lit_in   (smp[c]),
               .dark_in  (smp[c]),
               .lit_out  (lit_q[c][k]),
               .dark_out (dark_q[c][k])
            );
         end else begin : g_body
            irar_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift    (shift),
               .lit_in   (lit_q[c][k-1]),
               .dark_in  (dark_q[c][k-1]),
               .lit_out  (lit_q[c][k]),
               .dark_out (dark_q[c][k])
            );
         end
      end

      assign lit_sum_in[c] = shift.lit
         ? lit_sum_ff[c] + SUM_W'(smp[c]) - SUM_W'(lit_q[c][WINDOW_LEN-1])
         : lit_sum_ff[c];
      assign dark_sum_in[c] = shift.dark
         ? dark_sum_ff[c] + SUM_W'(smp[c]) - SUM_W'(dark_q[c][WINDOW_LEN-1])
         : dark_sum_ff[c];
   end

   // result pipeline control
   logic v1_ff, v2_ff, v3_ff, rsp_v_ff;
   logic v1_in, v2_in, v3_in, rsp_v_in;
   logic rdy1, rdy2, rdy3, adv4;
   logic e1_ff, e2_ff, e3_ff, rsp_e_ff;
   logic u1_ff, u2_ff, u3_ff, rsp_u_ff;
   logic held_load;
   irar_pkg::stage_ctl_type stage_ctl;

   assign adv4 = !rsp_v_ff || rsp_tready;
   assign rdy3 = !v3_ff || adv4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_tready = rdy1;

   assign v1_in    = rdy1 ? req_acc : v1_ff;
   assign v2_in    = rdy2 ? v1_ff   : v2_ff;
   assign v3_in    = rdy3 ? v2_ff   : v3_ff;
   assign rsp_v_in = adv4 ? v3_ff   : rsp_v_ff;

   assign stage_ctl.d_load = rdy2;
   assign stage_ctl.p_load = rdy3;
   assign held_load        = adv4 && v3_ff && u3_ff;

   // stage 1 payload: sums as left by this item
   logic [SUM_W-1:0] dsum1_ff [CH];
   logic [SUM_W-1:0] lsum1_ff [CH];
   logic [SUM_W-1:0] level_q  [CH];
   logic [LB-1:0]    held_ff  [CH];

   for (genvar c = 0; c < CH; c++) begin : g_lvl
      irar_level #(.SUM_W(SUM_W), .WINDOW_LEN(WINDOW_LEN)) u_level (
         .clock    (clock),
         .ctl      (stage_ctl),
         .dark_sum (dsum1_ff[c]),
         .lit_sum  (lsum1_ff[c]),
         .level    (level_q[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         step_ff   <= '0;
         emit_ff   <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         rsp_v_ff  <= 1'b0;
         for (int c = 0; c < CH; c++) begin
            lit_sum_ff[c]  <= '0;
            dark_sum_ff[c] <= '0;
            held_ff[c]     <= '0;
         end
      end else begin
         enable_ff <= enable_in;
         step_ff   <= step_in;
         emit_ff   <= emit_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
         rsp_v_ff  <= rsp_v_in;
         for (int c = 0; c < CH; c++) begin
            lit_sum_ff[c]  <= lit_sum_in[c];
            dark_sum_ff[c] <= dark_sum_in[c];
            if (held_load) begin
               held_ff[c] <= LB'(level_q[c]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         e1_ff <= emit_in;
         u1_ff <= is_dark;
         for (int c = 0; c < CH; c++) begin
            dsum1_ff[c] <= dark_sum_in[c];
            lsum1_ff[c] <= lit_sum_in[c];
         end
      end
      if (rdy2) begin
         e2_ff <= e1_ff;
         u2_ff <= u1_ff;
      end
      if (rdy3) begin
         e3_ff <= e2_ff;
         u3_ff <= u2_ff;
      end
      if (adv4) begin
         rsp_e_ff <= e3_ff;
         rsp_u_ff <= u3_ff;
      end
   end

   assign rsp_tvalid   = rsp_v_ff;
   assign rsp_tuser[0] = rsp_u_ff;
   assign rsp_tdata    = {{irar_pkg::RSP_PAD_BITS{1'b0}}, held_ff[irar_pkg::FRONT],
                          held_ff[irar_pkg::REAR], rsp_e_ff};

   `IRAR_ASSERT_NEXT(a_step_wraps, clock, reset, req_acc && is_dark, step_ff == '0,
      "step counter did not wrap after the off-window step")
   `IRAR_ASSERT_NEXT(a_held_stable, clock, reset, !held_load,
      $stable(held_ff[irar_pkg::REAR]) && $stable(held_ff[irar_pkg::FRONT]),
      "held level changed without an update transfer")
   `IRAR_ASSERT_NEXT(a_stage1_kept, clock, reset, v1_ff && !rdy2, v1_ff,
      "stage 1 item lost while downstream stalled")
   `IRAR_ASSERT_HOLDS(a_sum_range, clock, reset,
      (longint'(lit_sum_ff[irar_pkg::REAR]) <= SUM_MAX) &&
      (longint'(lit_sum_ff[irar_pkg::FRONT]) <= SUM_MAX) &&
      (longint'(dark_sum_ff[irar_pkg::REAR]) <= SUM_MAX) &&
      (longint'(dark_sum_ff[irar_pkg::FRONT]) <= SUM_MAX),
      "running window sum out of range")

endmodule

`default_nettype wire

FILE: rtl/irar_cell.sv
// One window cell: holds one emitter-on and one emitter-off sample of a channel.
// Depends on irar_pkg (shift_ctl_type).
`default_nettype none

module irar_cell #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire irar_pkg::shift_ctl_type shift,
   input  wire [SAMPLE_BITS-1:0]        lit_in,
   input  wire [SAMPLE_BITS-1:0]        dark_in,
   output logic [SAMPLE_BITS-1:0]       lit_out,
   output logic [SAMPLE_BITS-1:0]       dark_out
);

   logic [SAMPLE_BITS-1:0] lit_ff;
   logic [SAMPLE_BITS-1:0] dark_ff;
   logic [SAMPLE_BITS-1:0] lit_in_q;
   logic [SAMPLE_BITS-1:0] dark_in_q;

   assign lit_in_q  = shift.lit  ? lit_in  : lit_ff;
   assign dark_in_q = shift.dark ? dark_in : dark_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff  <= '0;
         dark_ff <= '0;
      end else begin
         lit_ff  <= lit_in_q;
         dark_ff <= dark_in_q;
      end
   end

   assign lit_out  = lit_ff;
   assign dark_out = dark_ff;

endmodule

`default_nettype wire

FILE: rtl/irar_level.sv
// Level unit of one channel: |dark sum - lit sum| / window length over two
// register stages (difference, reciprocal product), quotient fixed up at the end.
// Depends on irar_pkg (stage_ctl_type).
`default_nettype none

module irar_level #(
   parameter int SUM_W      = 14,
   parameter int WINDOW_LEN = 4
) (
   input  wire                          clock,
   input  wire irar_pkg::stage_ctl_type ctl,
   input  wire [SUM_W-1:0]              dark_sum,
   input  wire [SUM_W-1:0]              lit_sum,
   output logic [SUM_W-1:0]             level
);

   localparam longint RECIP = (64'd1 << SUM_W) / WINDOW_LEN;

   logic [SUM_W-1:0]   diff;
   logic [SUM_W-1:0]   d2_ff;
   logic [SUM_W-1:0]   d3_ff;
   logic [2*SUM_W-1:0] prod_ff;
   logic [SUM_W-1:0]   q0;
   logic [SUM_W-1:0]   rem;

   assign diff = (dark_sum >= lit_sum) ? dark_sum - lit_sum : lit_sum - dark_sum;

   always_ff @(posedge clock) begin
      if (ctl.d_load) begin
         d2_ff <= diff;
      end
      if (ctl.p_load) begin
         d3_ff   <= d2_ff;
         prod_ff <= (2*SUM_W)'(d2_ff) * (2*SUM_W)'(RECIP);
      end
   end

   // q0 is the quotient or one short of it
   assign q0    = prod_ff[2*SUM_W-1:SUM_W];
   assign rem   = d3_ff - SUM_W'(q0 * SUM_W'(WINDOW_LEN));
   assign level = (rem >= SUM_W'(WINDOW_LEN)) ? q0 + SUM_W'(1) : q0;

endmodule

`default_nettype wire

FILE: test/modulated_ir_ambient_rejection_tb.sv
// Self-checking testbench for modulated_ir_ambient_rejection: random sample ticks with
// bursty input, stalling output and emitter enable changes, checked against a tick predictor.
// Depends on irar_pkg and the modulated_ir_ambient_rejection RTL.
module modulated_ir_ambient_rejection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 4;
   localparam int STEPS       = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int TICK_LIMIT  = 200000;

   typedef logic [irar_pkg::FIELD_BITS-1:0] sample_type;
   typedef logic [irar_pkg::LEVEL_BITS-1:0] level_type;

   typedef struct packed {
      logic      emitter_on;
      level_type rear_level;
      level_type front_level;
      logic      levels_updated;
   } tick_status_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   class ambient_scoreboard;
      logic            enable;
      logic [3:0]      step;
      logic [2:0]      slot;
      logic            emitter;
      sample_type      lit_win[irar_pkg::CHANNELS][SLOTS];
      sample_type      dark_win[irar_pkg::CHANNELS][SLOTS];
      logic [13:0]     lit_sum[irar_pkg::CHANNELS];
      logic [13:0]     dark_sum[irar_pkg::CHANNELS];
      level_type       held[irar_pkg::CHANNELS];
      tick_status_type expected_status[$];
      int              errors;
      int              seen;

      function new();
         enable  = 1'b0;
         step    = '0;
         slot    = '0;
         emitter = 1'b0;
         foreach (lit_win[c, i]) begin
            lit_win[c][i]  = '0;
            dark_win[c][i] = '0;
         end
         foreach (held[c]) begin
            lit_sum[c]  = '0;
            dark_sum[c] = '0;
            held[c]     = '0;
         end
         errors = 0;
         seen   = 0;
      endfunction

      function void set_enable(logic v);
         enable = v;
      endfunction

      function void note_tick(sample_type rear, sample_type front);
         sample_type      smp[irar_pkg::CHANNELS];
         logic [13:0]     total;
         logic [13:0]     diff;
         tick_status_type st;
         smp[irar_pkg::REAR]  = rear;
         smp[irar_pkg::FRONT] = front;
         st.levels_updated = 1'b0;
         step = step + 4'd1;
         if (step == 4'd1) begin
            if (enable)
               emitter = 1'b1;
         end else if (step == 4'd2) begin
            if (slot >= SLOTS)
               slot = '0;
            for (int c = 0; c < irar_pkg::CHANNELS; c++) begin
               lit_win[c][slot] = smp[c];
               total = '0;
               for (int i = 0; i < SLOTS; i++)
                  total += lit_win[c][i];
               lit_sum[c] = total;
            end
            emitter = 1'b0;
         end else if (step == STEPS) begin
            if (slot >= SLOTS)
               slot = '0;
            for (int c = 0; c < irar_pkg::CHANNELS; c++) begin
               dark_win[c][slot] = smp[c];
               total = '0;
               for (int i = 0; i < SLOTS; i++)
                  total += dark_win[c][i];
               dark_sum[c] = total;
               diff = (dark_sum[c] >= lit_sum[c]) ? dark_sum[c] - lit_sum[c]
                                                  : lit_sum[c] - dark_sum[c];
               held[c] = level_type'(diff / SLOTS);
            end
            slot = slot + 3'd1;
            step = '0;
            st.levels_updated = 1'b1;
         end
         st.emitter_on  = emitter;
         st.rear_level  = held[irar_pkg::REAR];
         st.front_level = held[irar_pkg::FRONT];
         expected_status.push_back(st);
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         if (errors <= 40)
            $display("mismatch at result %0d, %0s: got %0d expected %0d", seen, what, got, want);
      endtask

      task check_status(logic [irar_pkg::RSP_DATA_BITS-1:0] data, logic user);
         tick_status_type want;
         if (expected_status.size() == 0) begin
            report_mismatch("result with nothing pending", int'(data), 0);
            return;
         end
         want = expected_status.pop_front();
         if (data[0] !== want.emitter_on)
            report_mismatch("emitter_on", data[0], want.emitter_on);
         if (data[12:1] !== want.rear_level)
            report_mismatch("rear_level", data[12:1], want.rear_level);
         if (data[24:13] !== want.front_level)
            report_mismatch("front_level", data[24:13], want.front_level);
         if (user !== want.levels_updated)
            report_mismatch("levels_updated", user, want.levels_updated);
         seen++;
      endtask
   endclass

   logic                                clock;
   logic                                reset      = 1'b1;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [0:0]                          csr_data   = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [irar_pkg::REQ_DATA_BITS-1:0]  req_tdata  = '0;  // rear_sample, front_sample
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [irar_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;        // emitter_on, rear_level,
                                                          // front_level, zero pad
   logic [0:0]                          rsp_tuser;        // levels_updated

   ambient_scoreboard sb = new();
   int                cycles      = 0;
   bit                hold_request = 1'b0;
   int                hold_left   = 0;
   int                mode_left   = 0;
   ready_mode_type    rdy_mode    = READY_ALWAYS;

   modulated_ir_ambient_rejection dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > TICK_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: check transfers, stall on a shifting pattern, long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_status(rsp_tdata, rsp_tuser[0]);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            rdy_mode  = ready_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rdy_mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               default:      rsp_tready <= (mode_left % 4 == 0);
            endcase
         end
      end
   end

   task automatic send_tick(input sample_type rear, input sample_type front);
      req_tvalid <= 1'b1;
      req_tdata  <= {front, rear};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(rear, front);
   endtask

   task automatic write_enable(input logic v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_enable(v);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return sample_type'($urandom_range(3900, 4095));
         3:       return sample_type'($urandom_range(0, 200));
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int count, input bit squeeze);
      int left;
      int burst;
      int gap;
      left = count;
      if (squeeze)
         hold_request = 1'b1;
      while (left > 0) begin
         burst = (squeeze && left == count) ? 60 : $urandom_range(1, 24);
         for (int k = 0; k < burst && left > 0; k++) begin
            send_tick(pick_sample(), pick_sample());
            left--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0 && left > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // three full step cycles: extreme lit/dark pairs, checkerboard elsewhere
      write_enable(1'b1);
      for (int i = 0; i < 3 * STEPS; i++) begin
         case (i % STEPS)
            1:         send_tick((i / STEPS) % 2 ? '0 : '1, (i / STEPS) % 2 ? '1 : '0);
            STEPS - 1: send_tick((i / STEPS) % 2 ? '1 : '0, (i / STEPS) % 2 ? '0 : '1);
            default:   send_tick(i % 2 ? 12'hAAA : 12'h555, i % 2 ? 12'h555 : 12'hAAA);
         endcase
      end

      wait_idle();
      write_enable(1'b0);
      random_phase(260, 1'b0);
      wait_idle();
      write_enable(1'b1);
      random_phase(260, 1'b1);
      wait_idle();
      write_enable(1'b0);
      random_phase(260, 1'b0);
      wait_idle();
      write_enable(1'b1);
      random_phase(260, 1'b0);
      wait_idle();
      repeat (12) @(posedge clock);

      if (sb.errors == 0 && sb.expected_status.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/irar_pkg.sv
rtl/irar_cell.sv
rtl/irar_level.sv
rtl/modulated_ir_ambient_rejection.sv
test/modulated_ir_ambient_rejection_tb.sv
